/* design/ptcs_pkg.sv */
// Package: shared types and constants of the ping transmit/capture sequencer.
`timescale 1ns / 1ps
package ptcs_pkg;

  localparam int unsigned GAIN_FRAC_BITS = 12;
  localparam int unsigned SCALED_W       = 32 - GAIN_FRAC_BITS;
  localparam int unsigned ADDR_W         = 5;

  localparam logic [15:0] STUCK_CODE          = 16'hFFFF;
  localparam logic [15:0] CAPTURE_LENGTH_RST  = 16'd1024;
  localparam logic [15:0] PULSE_LENGTH_RST    = 16'd64;
  localparam logic [15:0] CAL_GAIN_RST        = 16'd4096;
  localparam logic [15:0] SAMPLE_MAX_RST      = 16'd4095;
  localparam logic [7:0]  DAC_BIAS_RST        = 8'd128;

  typedef enum logic [2:0] {
    REG_CAPTURE_LENGTH = 3'd0,
    REG_PULSE_LENGTH   = 3'd1,
    REG_CAL_GAIN       = 3'd2,
    REG_SAMPLE_MAX     = 3'd3,
    REG_DAC_BIAS       = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] capture_length;
    logic [15:0] pulse_length;
    logic [15:0] cal_gain;
    logic [15:0] sample_max;
    logic [7:0]  dac_bias;
  } cfg_t;

  typedef struct packed {
    logic        start_req;
    logic [15:0] adc_raw;
    logic [7:0]  tx_sample;
  } in_item_t;

  typedef struct packed {
    logic        sample_valid;
    logic [15:0] sample_index;
    logic [15:0] sample_value;
    logic        dac_write;
    logic [7:0]  dac_value;
    logic        convert_next;
    logic        stuck;
    logic        last;
  } out_item_t;

endpackage

/* design/ptcs_cfg_regs.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module ptcs_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptcs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ptcs_pkg::cfg_t             cfg_o
);
  import ptcs_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_CAPTURE_LENGTH: cfg_d.capture_length = pwdata[15:0];
        REG_PULSE_LENGTH:   cfg_d.pulse_length   = pwdata[15:0];
        REG_CAL_GAIN:       cfg_d.cal_gain       = pwdata[15:0];
        REG_SAMPLE_MAX:     cfg_d.sample_max     = pwdata[15:0];
        REG_DAC_BIAS:       cfg_d.dac_bias       = pwdata[7:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CAPTURE_LENGTH: prdata = {16'd0, cfg_q.capture_length};
      REG_PULSE_LENGTH:   prdata = {16'd0, cfg_q.pulse_length};
      REG_CAL_GAIN:       prdata = {16'd0, cfg_q.cal_gain};
      REG_SAMPLE_MAX:     prdata = {16'd0, cfg_q.sample_max};
      REG_DAC_BIAS:       prdata = {24'd0, cfg_q.dac_bias};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capture_length <= CAPTURE_LENGTH_RST;
      cfg_q.pulse_length   <= PULSE_LENGTH_RST;
      cfg_q.cal_gain       <= CAL_GAIN_RST;
      cfg_q.sample_max     <= SAMPLE_MAX_RST;
      cfg_q.dac_bias       <= DAC_BIAS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/ptcs_seq.sv */
// Capture sequencer state and the per-sample result logic.
`timescale 1ns / 1ps
module ptcs_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  ptcs_pkg::in_item_t  item_i,
  input  ptcs_pkg::cfg_t      cfg_i,
  output ptcs_pkg::out_item_t result_o
);
  import ptcs_pkg::*;

  logic [15:0]         index_q, index_d;
  logic                active_q, active_d;
  logic                stuck_q, stuck_d;

  logic [15:0]         idx;
  logic                active, stuck_in;
  logic [15:0]         len_m1;
  logic                is_last;
  logic [31:0]         product;
  logic [SCALED_W-1:0] scaled;
  logic [15:0]         value;

  assign product = {16'd0, item_i.adc_raw} * {16'd0, cfg_i.cal_gain};
  assign scaled  = product[31:GAIN_FRAC_BITS];
  assign value   = (scaled > SCALED_W'(cfg_i.sample_max)) ? cfg_i.sample_max
                                                          : scaled[15:0];

  // Zero length behaves as one sample
  assign len_m1  = (cfg_i.capture_length == 16'd0) ? 16'd0
                                                   : cfg_i.capture_length - 16'd1;

  always_comb begin
    // A start request restarts the capture at index zero
    idx      = item_i.start_req ? 16'd0 : index_q;
    active   = item_i.start_req | active_q;
    stuck_in = item_i.start_req ? 1'b0 : stuck_q;
    is_last  = idx >= len_m1;

    result_o = '0;
    index_d  = index_q;
    active_d = active_q;
    stuck_d  = stuck_q;

    if (active) begin
      stuck_d               = stuck_in;
      result_o.sample_valid = 1'b1;
      result_o.sample_index = idx;
      result_o.last         = is_last;
      if (!stuck_in) begin
        result_o.convert_next = !is_last;
        if (idx < cfg_i.pulse_length) begin
          result_o.dac_write = 1'b1;
          result_o.dac_value = item_i.tx_sample;
        end else if (idx == cfg_i.pulse_length) begin
          result_o.dac_write = 1'b1;
          result_o.dac_value = cfg_i.dac_bias;
        end
        if (item_i.adc_raw == STUCK_CODE) begin
          stuck_d = 1'b1;
        end else begin
          result_o.sample_value = value;
        end
      end
      result_o.stuck = stuck_d;
      if (is_last) begin
        active_d = 1'b0;
        index_d  = 16'd0;
      end else begin
        active_d = 1'b1;
        index_d  = idx + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q  <= 16'd0;
      active_q <= 1'b0;
      stuck_q  <= 1'b0;
    end else if (step_i) begin
      index_q  <= index_d;
      active_q <= active_d;
      stuck_q  <= stuck_d;
    end
  end

endmodule

/* design/ping_transmit_capture_sequencer_core.sv */
// Top level: input register, sequencer logic, result register and config port.
// Path: an accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; the input and result registers both
// advance whenever the result register is empty or its result is taken.
// Reset: asynchronous, active low; clears valids and sequencer state and
// loads the register defaults. No clearing pass.
`timescale 1ns / 1ps
module ping_transmit_capture_sequencer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ptcs_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ptcs_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptcs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ptcs_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, result;
  logic      out_valid_q;
  logic      advance;
  logic      step;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  ptcs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptcs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/ptcs_checker.sv */
// Port-level checker for the sequencer core, bound to the top level.
`timescale 1ns / 1ps
module ptcs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ptcs_pkg::out_item_t out_data_o
);
  import ptcs_pkg::*;

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.sample_valid |-> out_data_o == '0)
    else $error("idle tick result not all zero");

  a_dac_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.dac_write |-> out_data_o.dac_value == 8'd0)
    else $error("DAC code present without a write");

  a_stuck_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.stuck || out_data_o.last)
      |-> (!out_data_o.last || !out_data_o.convert_next)
        && (!out_data_o.stuck || out_data_o.sample_value == 16'd0))
    else $error("conversion at last index or sample after stuck");

endmodule

bind ping_transmit_capture_sequencer_core ptcs_checker u_ptcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the ping transmit/capture sequencer core.
`timescale 1ns / 1ps
module tb_top;
  import ptcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_ITEMS = 110;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  // sequencer state and register copies used for prediction
  cfg_t                cfg_now;
  logic [15:0]         seq_index    = '0;
  logic                seq_active   = 1'b0;
  logic                seq_stuck    = 1'b0;

  in_item_t            ticks_to_send[$];
  out_item_t           expected_samples[$];
  int unsigned         mismatch_count = 0;
  int unsigned         send_wait      = 0;
  int unsigned         recv_wait      = 0;
  int unsigned         cycle_count    = 0;
  bit                  steady         = 1'b0;

  ping_transmit_capture_sequencer_core dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int unsigned draw_wait();
    if (steady) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
  endfunction

  // One sample tick: updates the sequencer copy and returns the expected result.
  function automatic out_item_t sequence_tick(in_item_t t);
    out_item_t   r;
    logic [15:0] span;
    logic [31:0] product;
    logic [31:0] scaled;
    logic        at_end;
    r = '0;
    if (t.start_req) begin
      seq_index  = '0;
      seq_active = 1'b1;
      seq_stuck  = 1'b0;
    end
    if (!seq_active) return r;
    span   = (cfg_now.capture_length == 16'd0) ? 16'd1 : cfg_now.capture_length;
    at_end = seq_index >= span - 16'd1;
    if (!seq_stuck) begin
      r.convert_next = !at_end;
      if (seq_index < cfg_now.pulse_length) begin
        r.dac_write = 1'b1;
        r.dac_value = t.tx_sample;
      end else if (seq_index == cfg_now.pulse_length) begin
        r.dac_write = 1'b1;
        r.dac_value = cfg_now.dac_bias;
      end
      if (t.adc_raw == STUCK_CODE) begin
        seq_stuck = 1'b1;
      end else begin
        product = 32'(t.adc_raw) * 32'(cfg_now.cal_gain);
        scaled  = product >> GAIN_FRAC_BITS;
        r.sample_value = (scaled > 32'(cfg_now.sample_max)) ? cfg_now.sample_max
                                                           : scaled[15:0];
      end
    end
    r.sample_valid = 1'b1;
    r.sample_index = seq_index;
    r.stuck        = seq_stuck;
    r.last         = at_end;
    if (at_end) begin
      seq_active = 1'b0;
      seq_index  = '0;
    end else begin
      seq_index = seq_index + 16'd1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 40) $display("tb_top: mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want,
                             logic [15:0] idx);
    if (got !== want)
      report_mismatch($sformatf("index %0d %s got %0h want %0h", idx, name, got, want));
  endtask

  task automatic check_sample(out_item_t got);
    out_item_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch("result with no request outstanding");
      return;
    end
    want = expected_samples.pop_front();
    check_field("sample_valid", 16'(got.sample_valid), 16'(want.sample_valid),
                want.sample_index);
    check_field("sample_index", got.sample_index, want.sample_index, want.sample_index);
    check_field("sample_value", got.sample_value, want.sample_value, want.sample_index);
    check_field("dac_write", 16'(got.dac_write), 16'(want.dac_write), want.sample_index);
    check_field("dac_value", 16'(got.dac_value), 16'(want.dac_value), want.sample_index);
    check_field("convert_next", 16'(got.convert_next), 16'(want.convert_next),
                want.sample_index);
    check_field("stuck", 16'(got.stuck), 16'(want.stuck), want.sample_index);
    check_field("last", 16'(got.last), 16'(want.last), want.sample_index);
  endtask

  // request driver: hold the payload while stalled, pause between requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_samples.push_back(sequence_tick(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (ticks_to_send.size() > 0) begin
          in_data_i  <= ticks_to_send.pop_front();
          in_valid_i <= 1'b1;
          send_wait  = draw_wait();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: check each taken result, then stall for a drawn while
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_sample(out_data_o);
        recv_wait = draw_wait();
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall_i <= (recv_wait > 0);
    end
  end

  task automatic reg_access(input bit wr, input reg_idx_e r, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_reg(reg_idx_e r, logic [15:0] v);
    logic [31:0] wdata;
    logic [31:0] rdata;
    logic [15:0] mask;
    mask  = (r == REG_DAC_BIAS) ? 16'h00FF : 16'hFFFF;
    // fill the unused bits with noise; the register must ignore them
    wdata = $urandom;
    wdata[15:0] = (wdata[15:0] & ~mask) | (v & mask);
    reg_access(1'b1, r, wdata, rdata);
    case (r)
      REG_CAPTURE_LENGTH: cfg_now.capture_length = v;
      REG_PULSE_LENGTH:   cfg_now.pulse_length   = v;
      REG_CAL_GAIN:       cfg_now.cal_gain       = v;
      REG_SAMPLE_MAX:     cfg_now.sample_max     = v;
      REG_DAC_BIAS:       cfg_now.dac_bias       = v[7:0];
      default: ;
    endcase
    reg_access(1'b0, r, 32'h0, rdata);
    if ((rdata[15:0] & mask) !== (v & mask))
      report_mismatch($sformatf("register %s reads %0h want %0h", r.name(),
                                rdata[15:0] & mask, v & mask));
  endtask

  task automatic program_settings(logic [15:0] len, logic [15:0] pulse, logic [15:0] gain,
                                  logic [15:0] ceiling, logic [7:0] bias);
    program_reg(REG_CAPTURE_LENGTH, len);
    program_reg(REG_PULSE_LENGTH, pulse);
    program_reg(REG_CAL_GAIN, gain);
    program_reg(REG_SAMPLE_MAX, ceiling);
    program_reg(REG_DAC_BIAS, {8'h00, bias});
  endtask

  task automatic push_tick(bit start, logic [15:0] raw, logic [7:0] tx);
    in_item_t t;
    t.start_req = start;
    t.adc_raw   = raw;
    t.tx_sample = tx;
    ticks_to_send.push_back(t);
  endtask

  // Hold the sender until every result is back, then let the pipeline settle.
  // Sample on the falling edge so the driver's updates have all landed.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (ticks_to_send.size() != 0 || in_valid_i || expected_samples.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFE;
      2:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 16'hFFFE));
    endcase
  endfunction

  // One capture from its start request; long ones are cut short and restarted.
  task automatic queue_capture(int unsigned span_cfg, inout int unsigned issued);
    int unsigned span;
    int          stuck_at;
    int unsigned i;
    span = span_cfg;
    if (span > 150) span = $urandom_range(1, 150);
    if ($urandom_range(0, 19) == 0) span = $urandom_range(1, span);
    stuck_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, span - 1)) : -1;
    for (i = 0; i < span; i++) begin
      if (int'(i) == stuck_at || $urandom_range(0, 59) == 0)
        push_tick(i == 0, STUCK_CODE, 8'($urandom));
      else
        push_tick(i == 0, pick_raw(), 8'($urandom));
    end
    issued += span;
    // ticks with no start request after the capture; idle unless it was cut short
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_tick(1'b0, pick_raw(), 8'($urandom));
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned issued;
    int unsigned span_cfg;
    logic [15:0] len;
    cfg_now = '{capture_length: CAPTURE_LENGTH_RST, pulse_length: PULSE_LENGTH_RST,
                cal_gain: CAL_GAIN_RST, sample_max: SAMPLE_MAX_RST,
                dac_bias: DAC_BIAS_RST};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: idle tick carrying the stuck code, then a saturating capture start
    push_tick(1'b0, STUCK_CODE, 8'hFF);
    push_tick(1'b1, 16'd5000, 8'hAA);
    push_tick(1'b0, 16'd0, 8'h55);
    wait_idle();

    // full-scale gain: waveform, bias write, stuck tick, then zeros to the last sample
    program_settings(16'd5, 16'd2, 16'hFFFF, 16'hFFFF, 8'hFF);
    push_tick(1'b1, 16'hFFFE, 8'hFF);
    push_tick(1'b0, 16'd1, 8'h00);
    push_tick(1'b0, 16'd4096, 8'h3C);
    push_tick(1'b0, STUCK_CODE, 8'hC3);
    push_tick(1'b0, 16'd100, 8'h11);
    push_tick(1'b0, 16'd12, 8'h22);
    // stuck while still in the pulse, then restart mid-capture
    push_tick(1'b1, 16'd7, 8'h01);
    push_tick(1'b0, STUCK_CODE, 8'h80);
    push_tick(1'b1, 16'd200, 8'h03);
    push_tick(1'b0, 16'h8000, 8'h7F);
    wait_idle();

    // zero capture length acts as one sample; zero gain and ceiling
    program_settings(16'd0, 16'd0, 16'd0, 16'd0, 8'h00);
    push_tick(1'b1, 16'hFFFE, 8'hFF);
    push_tick(1'b0, 16'd12, 8'h5A);
    push_tick(1'b1, STUCK_CODE, 8'hA5);
    wait_idle();

    // pulse longer than, then equal to, the capture: no bias write
    program_settings(16'd3, 16'hFFFF, CAL_GAIN_RST, SAMPLE_MAX_RST, DAC_BIAS_RST);
    push_tick(1'b1, 16'd300, 8'h10);
    push_tick(1'b0, 16'd301, 8'h20);
    push_tick(1'b0, 16'd302, 8'h30);
    wait_idle();
    program_settings(16'd3, 16'd3, 16'd8192, 16'd1000, 8'h40);
    push_tick(1'b1, 16'd400, 8'h40);
    push_tick(1'b0, 16'd600, 8'h50);
    push_tick(1'b0, 16'd800, 8'h60);

    for (phase = 0; phase < 12; phase++) begin
      wait_idle();
      steady = ($urandom_range(0, 3) == 0);
      case (phase)
        0: program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        1: program_settings(16'd1, 16'd0, 16'd0, 16'd0, 8'h00);
        2: program_settings(CAPTURE_LENGTH_RST, PULSE_LENGTH_RST, CAL_GAIN_RST,
                            SAMPLE_MAX_RST, DAC_BIAS_RST);
        default: begin
          case ($urandom_range(0, 9))
            0:       len = 16'd0;
            1:       len = 16'($urandom_range(200, 65535));
            default: len = 16'($urandom_range(1, 40));
          endcase
          span_cfg = (len == 16'd0) ? 1 : len;
          program_settings(len,
                           ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, span_cfg + 2)),
                           ($urandom_range(0, 4) == 0) ? CAL_GAIN_RST : 16'($urandom),
                           ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom),
                           8'($urandom));
        end
      endcase
      span_cfg = (cfg_now.capture_length == 16'd0) ? 1 : cfg_now.capture_length;
      issued = 0;
      while (issued < PHASE_ITEMS) queue_capture(span_cfg, issued);
    end

    wait_idle();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
